// ===== rtl/fbps_pkg.sv =====
`default_nettype none
package fbps_pkg;

    localparam logic [15:0] BANK_REG_ADDR = 16'h2100;

    localparam logic [2:0] KIND_WE_AUDIO = 3'd0;
    localparam logic [2:0] KIND_WE_WR    = 3'd1;
    localparam logic [2:0] KIND_BANK     = 3'd2;
    localparam logic [2:0] KIND_READ     = 3'd3;
    localparam logic [2:0] KIND_NONE     = 3'd4;

    localparam logic [1:0] ST_ISSUED     = 2'd0;
    localparam logic [1:0] ST_VERIFIED   = 2'd1;
    localparam logic [1:0] ST_REFUSED    = 2'd2;
    localparam logic [1:0] ST_UNEXPECTED = 2'd3;

    localparam logic       OP_PROGRAM    = 1'b0;
    localparam logic       OP_READ_BACK  = 1'b1;

    localparam logic [2:0] REG_UNLOCK_ADDR_FIRST  = 3'd0;
    localparam logic [2:0] REG_UNLOCK_DATA_FIRST  = 3'd1;
    localparam logic [2:0] REG_UNLOCK_ADDR_SECOND = 3'd2;
    localparam logic [2:0] REG_UNLOCK_DATA_SECOND = 3'd3;
    localparam logic [2:0] REG_UNLOCK_ADDR_THIRD  = 3'd4;
    localparam logic [2:0] REG_UNLOCK_DATA_THIRD  = 3'd5;
    localparam logic [2:0] REG_WE_ON_AUDIO_PIN    = 3'd6;
    localparam logic [2:0] REG_BANK_ONE_COMMANDS  = 3'd7;

    typedef struct packed {
        logic        opcode;
        logic [15:0] target_address;
        logic [7:0]  program_byte;
        logic [7:0]  current_bank;
        logic [7:0]  read_back;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  cycle_kind;
        logic [15:0] cycle_address;
        logic [7:0]  cycle_data;
        logic [1:0]  status;
        logic        last;
    } out_beat_t;

    // One classified job handed from the front to the back.
    typedef struct packed {
        logic        is_prog;
        logic [2:0]  kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  bank;
        logic [1:0]  status;
    } job_t;

    typedef struct packed {
        logic [15:0] addr_first;
        logic [7:0]  data_first;
        logic [15:0] addr_second;
        logic [7:0]  data_second;
        logic [15:0] addr_third;
        logic [7:0]  data_third;
        logic        we_on_audio;
        logic        bank_one;
    } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/fbps_front.sv =====
`default_nettype none
module fbps_front
    import fbps_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_beat_t s_data,
    input  wire logic     q_full,
    output logic          q_push,
    output job_t          q_job
);

    logic        polling_reg, polling_next;
    logic [15:0] pend_addr_reg, pend_addr_next;
    logic [7:0]  pend_byte_reg, pend_byte_next;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        polling_next   = polling_reg;
        pend_addr_next = pend_addr_reg;
        pend_byte_next = pend_byte_reg;
        q_job          = '0;
        q_job.kind     = KIND_NONE;
        if (s_data.opcode == OP_PROGRAM) begin
            if (polling_reg) begin
                q_job.status = ST_REFUSED;
            end else begin
                q_job.is_prog  = 1'b1;
                q_job.addr     = s_data.target_address;
                q_job.data     = s_data.program_byte;
                q_job.bank     = s_data.current_bank;
                q_job.status   = ST_ISSUED;
                polling_next   = 1'b1;
                pend_addr_next = s_data.target_address;
                pend_byte_next = s_data.program_byte;
            end
        end else begin
            if (!polling_reg) begin
                q_job.status = ST_UNEXPECTED;
            end else if (s_data.read_back == pend_byte_reg) begin
                q_job.addr   = pend_addr_reg;
                q_job.status = ST_VERIFIED;
                polling_next = 1'b0;
            end else begin
                q_job.kind   = KIND_READ;
                q_job.addr   = pend_addr_reg;
                q_job.status = ST_ISSUED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            polling_reg   <= 1'b0;
            pend_addr_reg <= '0;
            pend_byte_reg <= '0;
        end else if (q_push) begin
            polling_reg   <= polling_next;
            pend_addr_reg <= pend_addr_next;
            pend_byte_reg <= pend_byte_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/fbps_fifo.sv =====
`default_nettype none
module fbps_fifo
    import fbps_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head_job,
    output logic      empty,
    output logic      full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_FULL);
    assign head_job = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty)) else $error("queue underflow");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL) else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== rtl/fbps_back.sv =====
`default_nettype none
module fbps_back
    import fbps_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cfg_t cfg,
    input  wire job_t head_job,
    input  wire logic q_empty,
    output logic      q_pop,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_beat_t m_data
);

    localparam logic [2:0] STEP_BANK_SEL = 3'd0;
    localparam logic [2:0] STEP_UNLOCK1  = 3'd1;
    localparam logic [2:0] STEP_UNLOCK2  = 3'd2;
    localparam logic [2:0] STEP_UNLOCK3  = 3'd3;
    localparam logic [2:0] STEP_BANK_RST = 3'd4;
    localparam logic [2:0] STEP_DATA     = 3'd5;
    localparam logic [2:0] STEP_READ     = 3'd6;

    logic       busy_reg;
    logic [2:0] step_reg;
    job_t       cur_reg;
    logic       m_valid_reg;
    out_beat_t  out_reg;

    job_t       src;
    logic [2:0] step, step_after;
    logic [2:0] wk;
    logic       adv, have, fire, is_last;
    out_beat_t  beat;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        src        = busy_reg ? cur_reg : head_job;
        step       = busy_reg ? step_reg : (cfg.bank_one ? STEP_BANK_SEL : STEP_UNLOCK1);
        adv        = !m_valid_reg || m_ready;
        have       = busy_reg || !q_empty;
        fire       = adv && have;
        q_pop      = fire && !busy_reg;
        wk         = cfg.we_on_audio ? KIND_WE_AUDIO : KIND_WE_WR;
        is_last    = !src.is_prog || (step == STEP_READ);
        // skip the bank restore when bank-1 framing is off
        step_after = (step == STEP_UNLOCK3 && !cfg.bank_one) ? STEP_DATA : step + 3'd1;

        beat        = '0;
        beat.last   = is_last;
        beat.status = ST_ISSUED;
        if (!src.is_prog) begin
            beat.cycle_kind    = src.kind;
            beat.cycle_address = src.addr;
            beat.status        = src.status;
        end else begin
            unique case (step)
                STEP_BANK_SEL: begin
                    beat.cycle_kind    = KIND_BANK;
                    beat.cycle_address = BANK_REG_ADDR;
                    beat.cycle_data    = 8'd1;
                end
                STEP_UNLOCK1: begin
                    beat.cycle_kind    = wk;
                    beat.cycle_address = cfg.addr_first;
                    beat.cycle_data    = cfg.data_first;
                end
                STEP_UNLOCK2: begin
                    beat.cycle_kind    = wk;
                    beat.cycle_address = cfg.addr_second;
                    beat.cycle_data    = cfg.data_second;
                end
                STEP_UNLOCK3: begin
                    beat.cycle_kind    = wk;
                    beat.cycle_address = cfg.addr_third;
                    beat.cycle_data    = cfg.data_third;
                end
                STEP_BANK_RST: begin
                    beat.cycle_kind    = KIND_BANK;
                    beat.cycle_address = BANK_REG_ADDR;
                    beat.cycle_data    = src.bank;
                end
                STEP_DATA: begin
                    beat.cycle_kind    = wk;
                    beat.cycle_address = src.addr;
                    beat.cycle_data    = src.data;
                end
                STEP_READ: begin
                    beat.cycle_kind    = KIND_READ;
                    beat.cycle_address = src.addr;
                end
                default: begin
                    beat.cycle_kind = KIND_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg  <= beat;
            cur_reg  <= src;
            step_reg <= step_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            busy_reg    <= !is_last;
            m_valid_reg <= 1'b1;
        end else if (adv) begin
            m_valid_reg <= 1'b0;
        end
    end

    a_busy_prog: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cur_reg.is_prog) else $error("busy on a single-beat job");
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (step_reg != STEP_BANK_SEL && step_reg <= STEP_READ))
        else $error("step out of range");
    a_last_ends_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && is_last) |=> !busy_reg) else $error("job not closed on last beat");
    a_non_issued_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.status != ST_ISSUED) |-> out_reg.last)
        else $error("status beat without last");

endmodule
`default_nettype wire

// ===== rtl/flash_byte_program_sequencer_top.sv =====
// Flash byte-program sequencer.
// Input channel (s_valid/s_ready/s_data) takes one beat per request: a program
// request (address, byte, current bank) or a read-back byte seen while polling.
// Output channel (m_valid/m_ready/m_data) carries one beat per bus cycle, with
// last set on the final beat caused by an input beat.
// A program request while idle yields 5 beats (7 with bank-1 framing): three
// unlock writes, the data write and a first read; polling then begins. Each
// read-back yields one beat: another read, a verified report, or an error beat.
// The front classifies input beats and tracks polling state; a queue of
// QUEUE_DEPTH jobs feeds the back, which emits one beat per cycle from its
// output register while the receiver accepts and a job is waiting. Each input
// beat is queued first; the back then registers its beats for the output.
// When the receiver stalls, the output register holds, the back holds its step,
// and the input stays ready until the queue fills.
// Reset (aresetn low, synchronous) clears configuration, polling state, the queue
// and the output valid. Configuration writes (cfg_wr_en/cfg_index/cfg_wr_data)
// take effect at the clock edge and belong in idle periods only.
`default_nettype none
module flash_byte_program_sequencer_top
    import fbps_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_beat_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_beat_t        m_data,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wr_data
);

    cfg_t cfg_reg;
    logic q_full, q_empty, q_push, q_pop;
    job_t push_job, head_job;

    // Configuration registers: plain write port, no read-back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_UNLOCK_ADDR_FIRST:  cfg_reg.addr_first  <= cfg_wr_data;
                REG_UNLOCK_DATA_FIRST:  cfg_reg.data_first  <= cfg_wr_data[7:0];
                REG_UNLOCK_ADDR_SECOND: cfg_reg.addr_second <= cfg_wr_data;
                REG_UNLOCK_DATA_SECOND: cfg_reg.data_second <= cfg_wr_data[7:0];
                REG_UNLOCK_ADDR_THIRD:  cfg_reg.addr_third  <= cfg_wr_data;
                REG_UNLOCK_DATA_THIRD:  cfg_reg.data_third  <= cfg_wr_data[7:0];
                REG_WE_ON_AUDIO_PIN:    cfg_reg.we_on_audio <= cfg_wr_data[0];
                REG_BANK_ONE_COMMANDS:  cfg_reg.bank_one    <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Front: accept and classify, track polling and the pending byte.
    fbps_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (push_job)
    );

    // Job queue between front and back.
    fbps_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    // Back: expand each job into bus-cycle beats.
    fbps_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head_job (head_job),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire
